/* hw/rtl/sgf_pkg.sv */
// Shared types, constants and helpers for the separable Gaussian filter.
// Used by sgf_ctrl, sgf_datapath, separable_gaussian_filter_top and the testbench; no dependencies.
package sgf_pkg;

	// Default build sizes.
	localparam int MAX_RADIUS_DEF = 3;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Configuration port shape.
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS,
		REG_EDGE_MODE,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_ROW_LO,
		REG_ROW_HI,
		REG_COL_LO,
		REG_COL_HI
	} cfg_reg_t;

	// Boundary handling codes; any other code behaves as zero padding.
	localparam logic [1:0] MODE_ZERO   = 2'd0;
	localparam logic [1:0] MODE_MIRROR = 2'd1;
	localparam logic [1:0] MODE_ADJUST = 2'd2;

	// Input item kinds.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// Reset values of the weight registers: taps {17963, 29610, 17963}.
	localparam logic [63:0] WEIGHTS_LO_RST = 64'd77152438076971;
	localparam logic [47:0] WEIGHTS_HI_RST = 48'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAPS,
		ST_DRAIN,
		ST_DIVIDE,
		ST_FINISH
	} sgf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic restart;
		logic start_taps;
		logic tap_issue;
		logic div_load;
		logic div_step;
		logic finish;
	} sgf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic due;
		logic stale;
		logic last_tap;
		logic pipe_busy;
		logic adjust;
		logic div_last;
		logic out_free;
	} sgf_status_t;

	// Q0.16 weight of tap k from a low word (taps 0..3) and a high word (taps 4..6).
	function automatic logic [15:0] tap_weight(input logic [63:0] lo, input logic [47:0] hi,
			input logic [3:0] k);
		logic [15:0] w;
		begin
			w = 16'd0;
			if (k < 4'd4)
				w = lo[16*k[1:0] +: 16];
			else if (k < 4'd7)
				w = hi[16*(k[1:0] - 2'd0) +: 16];
			return w;
		end
	endfunction

endpackage

/* hw/rtl/sgf_ctrl.sv */
// Sequencing state machine of the separable Gaussian filter.
// Depends on sgf_pkg; drives sgf_datapath through sgf_cmd_t.
module sgf_ctrl import sgf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  sgf_status_t status,
	output sgf_cmd_t    cmd
);

	sgf_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.stale) begin
					cmd.restart = 1'b1;
					state_d     = ST_IDLE;
				end else if (status.due) begin
					cmd.start_taps = 1'b1;
					state_d        = ST_TAPS;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TAPS: begin
				cmd.tap_issue = 1'b1;
				if (status.last_tap)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					if (status.adjust) begin
						cmd.div_load = 1'b1;
						state_d      = ST_DIVIDE;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/sgf_datapath.sv */
// Datapath of the separable Gaussian filter: registers, line memory, tap pipeline,
// divider and output register. Depends on sgf_pkg; commanded by sgf_ctrl.
module sgf_datapath import sgf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [7:0]            pixel_in,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [7:0]            pixel_out,
	output logic                  frame_end,
	input  sgf_cmd_t              cmd,
	output sgf_status_t           status
);

	localparam int RING   = 2 * MAX_RADIUS + 2;
	localparam int RW     = $clog2(RING);
	localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DW     = $clog2(MAXDIM + 1);
	localparam int SW     = DW + 2;
	localparam int DEPTH  = RING * MAX_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int TAPN   = 2 * MAX_RADIUS + 1;
	localparam int TW     = $clog2(TAPN);
	localparam int RADW   = $clog2(MAX_RADIUS + 1);
	localparam int ACCB   = $clog2(TAPN * TAPN);
	localparam int NUM_W  = 40 + ACCB;
	localparam int DEN_W  = 32 + ACCB;

	// Mirror a position about the centre, then clamp it into the image.
	function automatic logic signed [SW-1:0] mirror_pos(input logic signed [SW-1:0] p,
			input logic signed [SW-1:0] off, input logic signed [SW-1:0] n);
		logic signed [SW-1:0] q;
		begin
			q = p + off;
			if (q > n - SW'(1))
				q = p - off;
			else if (q < 0)
				q = -q;
			if (q < 0)
				q = '0;
			if (q > n - SW'(1))
				q = n - SW'(1);
			return q;
		end
	endfunction

	// Configuration registers.
	logic [1:0]  radius_q, edge_mode_q;
	logic [10:0] width_q, height_q;
	logic [63:0] row_lo_q, col_lo_q;
	logic [47:0] row_hi_q, col_hi_q;
	logic        geom_write;

	assign geom_write = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_EDGE_MODE ||
		cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= 2'd1;
			edge_mode_q <= MODE_ZERO;
			width_q     <= 11'd512;
			height_q    <= 11'd512;
			row_lo_q    <= WEIGHTS_LO_RST;
			row_hi_q    <= WEIGHTS_HI_RST;
			col_lo_q    <= WEIGHTS_LO_RST;
			col_hi_q    <= WEIGHTS_HI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:       radius_q    <= cfg_data[1:0];
				REG_EDGE_MODE:    edge_mode_q <= cfg_data[1:0];
				REG_IMAGE_WIDTH:  width_q     <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_data[10:0];
				REG_ROW_LO:       row_lo_q    <= cfg_data;
				REG_ROW_HI:       row_hi_q    <= cfg_data[47:0];
				REG_COL_LO:       col_lo_q    <= cfg_data;
				REG_COL_HI:       col_hi_q    <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// Effective radius and geometry.
	logic [RADW-1:0] r_eff;
	logic [DW-1:0]   w_eff, h_eff;
	logic            mirror_mode, adjust_mode;

	always_comb begin
		if (radius_q == 2'd0)
			r_eff = RADW'(1);
		else if (32'(radius_q) > MAX_RADIUS)
			r_eff = RADW'(MAX_RADIUS);
		else
			r_eff = RADW'(radius_q);
		if (width_q == 11'd0)
			w_eff = DW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = DW'(MAX_WIDTH);
		else
			w_eff = DW'(width_q);
		if (height_q == 11'd0)
			h_eff = DW'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = DW'(MAX_HEIGHT);
		else
			h_eff = DW'(height_q);
	end

	assign mirror_mode = (edge_mode_q == MODE_MIRROR);
	assign adjust_mode = (edge_mode_q == MODE_ADJUST);

	// Positions and ring lines of the input and output raster.
	logic [DW-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic [RW-1:0] in_ring_q, out_ring_q;
	logic          pix_write, out_last;

	assign pix_write = cmd.take && (req_type == REQ_PIXEL) && (in_row_q < h_eff) &&
		(in_col_q < w_eff);
	assign out_last  = (out_row_q == h_eff - DW'(1)) && (out_col_q == w_eff - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_ring_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_ring_q <= '0;
		end else if (geom_write || cmd.restart || (cmd.finish && out_last)) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_ring_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_ring_q <= '0;
		end else begin
			if (pix_write) begin
				if (in_col_q == w_eff - DW'(1)) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + DW'(1);
					in_ring_q <= (in_ring_q == RW'(RING - 1)) ? '0 : in_ring_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + DW'(1);
				end
			end
			if (cmd.finish) begin
				if (out_col_q == w_eff - DW'(1)) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + DW'(1);
					out_ring_q <= (out_ring_q == RW'(RING - 1)) ? '0 : out_ring_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + DW'(1);
				end
			end
		end
	end

	// Whether the next output has its whole window in the line memory.
	logic [DW:0] nr_sum, nc_sum;
	logic [DW-1:0] nr, nc;

	always_comb begin
		nr_sum = {1'b0, out_row_q} + (DW+1)'(r_eff);
		nc_sum = {1'b0, out_col_q} + (DW+1)'(r_eff);
		nr = (nr_sum > {1'b0, h_eff - DW'(1)}) ? h_eff - DW'(1) : nr_sum[DW-1:0];
		nc = (nc_sum > {1'b0, w_eff - DW'(1)}) ? w_eff - DW'(1) : nc_sum[DW-1:0];
	end

	assign status.due   = (in_row_q >= h_eff) || (in_row_q > nr) ||
		((in_row_q == nr) && (in_col_q > nc));
	assign status.stale = (out_row_q >= h_eff) || (out_col_q >= w_eff);

	// Tap counters: row tap outer, column tap inner.
	logic [TW-1:0] ta_q, tb_q, tmax;

	assign tmax = TW'(2 * r_eff);
	assign status.last_tap = (ta_q == tmax) && (tb_q == tmax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ta_q <= '0;
			tb_q <= '0;
		end else if (cmd.start_taps) begin
			ta_q <= '0;
			tb_q <= '0;
		end else if (cmd.tap_issue) begin
			if (tb_q == tmax) begin
				tb_q <= '0;
				ta_q <= ta_q + TW'(1);
			end else begin
				tb_q <= tb_q + TW'(1);
			end
		end
	end

	// Tap address and kernel weight for the current tap.
	logic signed [SW-1:0] p_row, p_col, n_row, n_col, off_a, off_b;
	logic signed [SW-1:0] row_sum, col_sum, row_sel, col_sel, ring_sum;
	logic                 row_in, col_in, tap_use;
	logic [RW-1:0]        tap_ring;
	logic [AW-1:0]        tap_addr;
	logic [15:0]          wr, wc;

	always_comb begin
		p_row   = SW'(out_row_q);
		p_col   = SW'(out_col_q);
		n_row   = SW'(h_eff);
		n_col   = SW'(w_eff);
		off_a   = SW'(ta_q) - SW'(r_eff);
		off_b   = SW'(tb_q) - SW'(r_eff);
		row_sum = p_row + off_a;
		col_sum = p_col + off_b;
		row_in  = (row_sum >= 0) && (row_sum < n_row);
		col_in  = (col_sum >= 0) && (col_sum < n_col);
		if (mirror_mode) begin
			row_sel = mirror_pos(p_row, off_a, n_row);
			col_sel = mirror_pos(p_col, off_b, n_col);
			tap_use = 1'b1;
		end else begin
			row_sel = row_sum;
			col_sel = col_sum;
			tap_use = row_in && col_in;
		end
		// Row offsets stay within two radii, so one wrap step finds the ring line.
		ring_sum = row_sel - p_row + SW'(out_ring_q);
		if (ring_sum < 0)
			ring_sum = ring_sum + SW'(RING);
		else if (ring_sum >= SW'(RING))
			ring_sum = ring_sum - SW'(RING);
		tap_ring = RW'(ring_sum);
		tap_addr = AW'(tap_ring) * AW'(MAX_WIDTH) + AW'(col_sel);
		wr = tap_weight(row_lo_q, row_hi_q, 4'(ta_q));
		wc = tap_weight(col_lo_q, col_hi_q, 4'(tb_q));
	end

	// Multiply-accumulate pipeline; outside mirror mode a tap that falls outside the image drops out.
	logic          use_s1, use_s2, use_s3;
	logic [AW-1:0] addr_s1;
	logic [31:0]   wk_s1, wk_s2, wk_s3;
	logic [7:0]    rd_s2;
	logic [39:0]   prod_s3;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [7:0]    line_mem [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_s1 <= 1'b0;
			use_s2 <= 1'b0;
			use_s3 <= 1'b0;
		end else begin
			use_s1 <= cmd.tap_issue && tap_use;
			use_s2 <= use_s1;
			use_s3 <= use_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= tap_addr;
		wk_s1   <= wr * wc;
		wk_s2   <= wk_s1;
		prod_s3 <= 40'(rd_s2) * 40'(wk_s2);
		wk_s3   <= wk_s2;
	end

	// Line memory: pixel write on accept, one registered read per tap.
	always_ff @(posedge clk) begin
		if (pix_write)
			line_mem[AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q)] <= pixel_in;
		rd_s2 <= line_mem[addr_s1];
	end

	always_ff @(posedge clk) begin
		if (cmd.start_taps) begin
			num_q <= '0;
			den_q <= '0;
		end else if (use_s3) begin
			num_q <= num_q + NUM_W'(prod_s3);
			den_q <= den_q + DEN_W'(wk_s3);
		end
	end

	assign status.pipe_busy = use_s1 || use_s2 || use_s3;
	assign status.adjust    = adjust_mode;

	// Restoring divider for the adjusted kernel: eight quotient bits, one per cycle.
	logic [NUM_W-1:0] rem_q, dsh_q;
	logic [7:0]       quo_q;
	logic [2:0]       dcnt_q;

	assign status.div_last = (dcnt_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_load) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= num_q;
			dsh_q <= {den_q, 7'd0, 1'b0} >> 1;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				quo_q <= {quo_q[6:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// Result selection with saturation.
	logic [NUM_W-33:0] num_int;
	logic [7:0]        res;
	logic              over;

	always_comb begin
		num_int = num_q[NUM_W-1:32];
		over    = num_q >= {den_q, 8'd0};
		if (adjust_mode) begin
			if (den_q == '0)
				res = 8'd0;
			else if (over)
				res = 8'd255;
			else
				res = quo_q;
		end else begin
			res = (num_int > (NUM_W-32)'(255)) ? 8'd255 : num_int[7:0];
		end
	end

	// Output register.
	logic       m_tvalid_q, frame_end_q;
	logic [7:0] pixel_out_q;

	assign status.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.finish)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pixel_out_q <= res;
			frame_end_q <= out_last;
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten before transfer");

	// A finished result shows up on the output in the next cycle.
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid_q)
		else $error("finished result not presented");

	// Taps are never issued while the divider is running.
	a_no_tap_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.tap_issue && !status.pipe_busy)
		else $error("tap pipeline active during division");

endmodule

/* hw/rtl/separable_gaussian_filter_top.sv */
// Per input transfer the block takes the item and checks whether an output is due; if one is, it
// issues every tap, drains the pipeline, divides in adjusted-kernel mode and writes the result. The
// window is summed one tap per cycle through a single multiply-accumulate fed by the one read port
// of the line memory, and the adjusted-kernel quotient comes from an eight-step restoring divider.
// A result waits in an output register, so the next pixel is taken while it is still pending.
// Send flush items (tuser = 1) after the last pixel until the frame_end result (tlast) appears.
// Top level of the separable Gaussian filter; depends on sgf_pkg, sgf_ctrl and sgf_datapath.
module separable_gaussian_filter_top import sgf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] pixel_in
	input  logic                  s_tuser,   // [0] req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] pixel_out
	output logic                  m_tlast    // frame_end
);

	sgf_cmd_t    cmd;
	sgf_status_t status;

	sgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sgf_datapath #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_type  (s_tuser),
		.pixel_in  (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.pixel_out (m_tdata),
		.frame_end (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the separable Gaussian filter: random and corner-case frames.
// Depends on sgf_pkg and separable_gaussian_filter_top; predicts every result internally.
`timescale 1ns / 1ps

module testbench;
	import sgf_pkg::*;

	localparam int RING = 2 * MAX_RADIUS_DEF + 2;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic [7:0] pixel;
		logic       last;
	} blur_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] pixel_in
	logic                  s_tuser;   // [0] req_type
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;   // [7:0] pixel_out
	logic                  m_tlast;   // frame_end

	// Predictor copy of the block's registers and state.
	logic [1:0]  cur_radius;
	logic [1:0]  cur_mode;
	logic [10:0] cur_width;
	logic [10:0] cur_height;
	logic [63:0] row_lo, col_lo;
	logic [47:0] row_hi, col_hi;
	logic [7:0]  lines [RING * MAX_WIDTH_DEF];
	int          in_r, in_c, out_r, out_c;
	bit          frame_done;

	blur_result_t pending_pixels[$];
	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  frames_done;
	bit  steady;
	int  hold_left;

	separable_gaussian_filter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what);
		begin
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	function automatic longint unsigned tap_w(input logic [63:0] lo, input logic [47:0] hi,
			input int k);
		begin
			if (k < 4)
				return longint'(lo[16*k +: 16]);
			if (k < 7)
				return longint'(hi[16*(k-4) +: 16]);
			return 0;
		end
	endfunction

	// Reflect an out-of-range offset about the center, then clamp into the image.
	function automatic int reflect_pos(input int p, input int off, input int n);
		int q;
		begin
			q = p + off;
			if (q > n - 1)
				q = p - off;
			else if (q < 0)
				q = -q;
			if (q < 0)
				q = 0;
			if (q > n - 1)
				q = n - 1;
			return q;
		end
	endfunction

	function automatic int eff_radius();
		begin
			if (cur_radius == 2'd0)
				return 1;
			return (int'(cur_radius) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(cur_radius);
		end
	endfunction

	function automatic int eff_dim(input logic [10:0] v, input int lim);
		begin
			if (v == 11'd0)
				return 1;
			return (int'(v) > lim) ? lim : int'(v);
		end
	endfunction

	// Weighted window sum for output position (i,j).
	function automatic logic [7:0] blur_at(input int i, input int j, input int r, input int h,
			input int w);
		longint unsigned num, den, wk;
		int ri, cj;
		begin
			num = 0;
			den = 0;
			for (int a = -r; a <= r; a++) begin
				for (int b = -r; b <= r; b++) begin
					wk = tap_w(row_lo, row_hi, a + r) * tap_w(col_lo, col_hi, b + r);
					ri = i + a;
					cj = j + b;
					if (cur_mode == MODE_MIRROR) begin
						ri = reflect_pos(i, a, h);
						cj = reflect_pos(j, b, w);
					end else if (ri < 0 || ri > h - 1 || cj < 0 || cj > w - 1) begin
						continue;
					end
					num += wk * lines[(ri % RING) * MAX_WIDTH_DEF + cj];
					den += wk;
				end
			end
			if (cur_mode == MODE_ADJUST) begin
				if (den == 0)
					return 8'd0;
				num = num / den;
			end else begin
				num = num >> 32;
			end
			return (num > 255) ? 8'd255 : num[7:0];
		end
	endfunction

	// Advance the predicted state by one accepted transfer and queue any result.
	task automatic predict_item(input logic req, input logic [7:0] pix);
		int r, w, h, nr, nc;
		bit due;
		blur_result_t res;
		begin
			r = eff_radius();
			w = eff_dim(cur_width, MAX_WIDTH_DEF);
			h = eff_dim(cur_height, MAX_HEIGHT_DEF);
			if (req == REQ_PIXEL && in_r < h && in_c < w) begin
				lines[(in_r % RING) * MAX_WIDTH_DEF + in_c] = pix;
				in_c++;
				if (in_c >= w) begin
					in_c = 0;
					in_r++;
				end
			end
			if (in_r >= h) begin
				due = 1'b1;
			end else begin
				nr = (out_r + r > h - 1) ? h - 1 : out_r + r;
				nc = (out_c + r > w - 1) ? w - 1 : out_c + r;
				due = (in_r > nr) || (in_r == nr && in_c > nc);
			end
			if (due) begin
				res.pixel = blur_at(out_r, out_c, r, h, w);
				res.last = (out_r == h - 1 && out_c == w - 1);
				pending_pixels.push_back(res);
				if (res.last) begin
					in_r = 0;
					in_c = 0;
					out_r = 0;
					out_c = 0;
					frame_done = 1'b1;
				end else begin
					out_c++;
					if (out_c >= w) begin
						out_c = 0;
						out_r++;
					end
				end
			end
		end
	endtask

	// Offer one item, idling now and then, and predict it once it is transferred.
	task automatic send_item(input logic req, input logic [7:0] pix);
		begin
			if (!steady && $urandom_range(99) < 18) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser <= req;
			s_tdata <= pix;
			do
				@(posedge clk);
			while (!s_tready);
			items_sent++;
			predict_item(req, pix);
		end
	endtask

	// Let the block go idle, then write one register.
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		begin
			s_tvalid <= 1'b0;
			wait (pending_pixels.size() == 0);
			repeat (DRAIN_CYCLES) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			@(posedge clk);
			cfg_we <= 1'b0;
			case (idx)
				REG_RADIUS:       cur_radius = value[1:0];
				REG_EDGE_MODE:    cur_mode = value[1:0];
				REG_IMAGE_WIDTH:  cur_width = value[10:0];
				REG_IMAGE_HEIGHT: cur_height = value[10:0];
				REG_ROW_LO:       row_lo = value;
				REG_ROW_HI:       row_hi = value[47:0];
				REG_COL_LO:       col_lo = value;
				REG_COL_HI:       col_hi = value[47:0];
				default: ;
			endcase
			if (idx <= REG_IMAGE_HEIGHT) begin
				in_r = 0;
				in_c = 0;
				out_r = 0;
				out_c = 0;
			end
		end
	endtask

	task automatic set_geometry(input int r, input int mode, input int w, input int h);
		begin
			write_reg(REG_RADIUS, {$urandom, $urandom} & ~64'h3 | 64'(r));
			write_reg(REG_EDGE_MODE, 64'(mode));
			write_reg(REG_IMAGE_WIDTH, 64'(w));
			write_reg(REG_IMAGE_HEIGHT, 64'(h));
		end
	endtask

	task automatic set_weights(input logic [63:0] rl, input logic [47:0] rh,
			input logic [63:0] cl, input logic [47:0] ch);
		begin
			write_reg(REG_ROW_LO, rl);
			write_reg(REG_ROW_HI, {16'hFFFF, rh});
			write_reg(REG_COL_LO, cl);
			write_reg(REG_COL_HI, {16'hA5A5, ch});
		end
	endtask

	// One whole frame: pixels with stray flushes, then flushes and extra pixels until frame end.
	task automatic run_frame(input int mix_pct);
		begin
			frame_done = 1'b0;
			while (in_r < eff_dim(cur_height, MAX_HEIGHT_DEF) && !frame_done) begin
				if ($urandom_range(99) < mix_pct)
					send_item(REQ_FLUSH, 8'($urandom));
				else
					send_item(REQ_PIXEL, 8'($urandom));
			end
			while (!frame_done)
				send_item(($urandom_range(99) < 70) ? REQ_FLUSH : REQ_PIXEL, 8'($urandom));
			frames_done++;
		end
	endtask

	// Corner values: tiny images, out-of-range radius, mode three, saturation, zero weights.
	task automatic test_directed();
		begin
			set_geometry(0, 3, 1, 1);
			frame_done = 1'b0;
			send_item(REQ_PIXEL, 8'hFF);
			while (!frame_done)
				send_item(REQ_FLUSH, 8'h00);
			set_weights({4{16'hFFFF}}, {3{16'hFFFF}}, {4{16'hFFFF}}, {3{16'hFFFF}});
			set_geometry(3, 0, 3, 2);
			frame_done = 1'b0;
			for (int k = 0; k < 6; k++)
				send_item(REQ_PIXEL, (k % 2) ? 8'hFF : 8'h00);
			while (!frame_done)
				send_item(REQ_FLUSH, 8'hFF);
			set_weights(64'd0, 48'd0, 64'd0, 48'd0);
			set_geometry(2, 2, 2, 3);
			run_frame(10);
			set_weights(WEIGHTS_LO_RST, WEIGHTS_HI_RST, WEIGHTS_LO_RST, WEIGHTS_HI_RST);
			set_geometry(3, 1, 2, 2);
			run_frame(10);
		end
	endtask

	// Random small frames over all settings, with every seventh frame run idle-free.
	task automatic test_random_frames();
		begin
			while (items_sent < 360) begin
				set_weights({$urandom, $urandom}, 48'({$urandom, $urandom}),
					{$urandom, $urandom}, 48'({$urandom, $urandom}));
				set_geometry($urandom_range(3), $urandom_range(3), $urandom_range(0, 7),
					$urandom_range(0, 6));
				steady = (frames_done % 7) == 3;
				run_frame(8);
				steady = 1'b0;
			end
		end
	endtask

	// Geometry above the build maxima: the start of one long line and of one tall column,
	// each cut short by the next geometry write.
	task automatic test_large_geometry();
		begin
			set_geometry(3, 1, 2047, 1);
			for (int k = 0; k < 20; k++)
				send_item(REQ_PIXEL, 8'($urandom));
			set_geometry(2, 2, 1, 1030);
			for (int k = 0; k < 20; k++)
				send_item(REQ_PIXEL, 8'($urandom));
			set_geometry(1, 0, 4, 4);
		end
	endtask

	// Receiver holds off for a long stretch while pixels keep being offered.
	task automatic test_backpressure();
		begin
			set_weights(WEIGHTS_LO_RST, WEIGHTS_HI_RST, WEIGHTS_LO_RST, WEIGHTS_HI_RST);
			set_geometry(1, 0, 6, 5);
			hold_left = 600;
			steady = 1'b1;
			run_frame(0);
			steady = 1'b0;
		end
	endtask

	// Check every result transfer against the oldest prediction; drive the receiver side.
	always @(posedge clk) begin
		blur_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", m_tdata));
			end else begin
				exp_res = pending_pixels.pop_front();
				if (m_tdata !== exp_res.pixel)
					report_mismatch($sformatf("pixel_out %0d, predicted %0d", m_tdata,
						exp_res.pixel));
				if (m_tlast !== exp_res.last)
					report_mismatch($sformatf("frame_end %b, predicted %b", m_tlast,
						exp_res.last));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RADIUS;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_PIXEL;
		m_tready <= 1'b0;
		cur_radius = 2'd1;
		cur_mode = MODE_ZERO;
		cur_width = 11'd512;
		cur_height = 11'd512;
		row_lo = WEIGHTS_LO_RST;
		col_lo = WEIGHTS_LO_RST;
		row_hi = WEIGHTS_HI_RST;
		col_hi = WEIGHTS_HI_RST;
		foreach (lines[k])
			lines[k] = 8'd0;
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		frames_done = 0;
		steady = 1'b0;
		hold_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_frames();
		test_large_geometry();

		s_tvalid <= 1'b0;
		wait (pending_pixels.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d frames, %0d transfers in, %0d results out,", frames_done,
			items_sent, results_seen);
		$display("all edge modes, radii and weight extremes, with stalls on both sides.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#60ms;
		$display("timeout with %0d results outstanding", pending_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sgf_pkg.sv
hw/rtl/sgf_ctrl.sv
hw/rtl/sgf_datapath.sv
hw/rtl/separable_gaussian_filter_top.sv
dv/testbench.sv
